// ===== design/stl_pkg.sv =====
// ----------------------------------------------------------------------------
// stl_pkg: shared types and decode helpers for the s-expression lexer
// request formats, lexer modes, result kinds and character classifiers
// ----------------------------------------------------------------------------
package stl_pkg;

  localparam int unsigned STL_QUEUE_DEPTH = 4;

  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_OPEN   = 8'h28;
  localparam logic [7:0] CH_CLOSE  = 8'h29;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_X      = 8'h78;

  typedef enum logic [2:0] {
    MODE_IDLE   = 3'd0,
    MODE_SYMBOL = 3'd1,
    MODE_STRING = 3'd2,
    MODE_ESCAPE = 3'd3,
    MODE_HEX1   = 3'd4,
    MODE_HEX2   = 3'd5,
    MODE_ERROR  = 3'd6
  } lex_mode_t;

  typedef enum logic [2:0] {
    KIND_TEXT   = 3'd0,
    KIND_OPEN   = 3'd1,
    KIND_CLOSE  = 3'd2,
    KIND_SYMEND = 3'd3,
    KIND_STREND = 3'd4,
    KIND_EOF    = 3'd5,
    KIND_ERROR  = 3'd6
  } kind_t;

  typedef struct packed {
    logic [7:0] char_in;
    logic       end_mark;
  } in_req_t;

  typedef struct packed {
    kind_t       result_kind;
    logic [7:0]  text_byte;
    logic [31:0] row_now;
    logic [31:0] column_now;
    logic [31:0] position_now;
    logic        last_of_run;
  } out_req_t;

  // one classified input item with one or two results to deliver
  typedef struct packed {
    kind_t       first_kind;
    logic [7:0]  first_byte;
    logic        two;
    kind_t       second_kind;
    logic [31:0] row;
    logic [31:0] col;
    logic [31:0] pos;
  } job_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  // bit 4 set: not a hex digit
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    v = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) v = {1'b0, 4'(c - 8'h30)};
    else if (c >= 8'h61 && c <= 8'h66) v = {1'b0, 4'(c - 8'h57)};
    else if (c >= 8'h41 && c <= 8'h46) v = {1'b0, 4'(c - 8'h37)};
    return v;
  endfunction

  // bit 8 set: unknown escape letter
  function automatic logic [8:0] escape_byte(input logic [7:0] c);
    logic [8:0] v;
    unique case (c)
      8'h61:   v = 9'd7;
      8'h62:   v = 9'd8;
      8'h66:   v = 9'd12;
      8'h6e:   v = 9'd10;
      8'h72:   v = 9'd13;
      8'h74:   v = 9'd9;
      8'h76:   v = 9'd11;
      8'h5c:   v = 9'h05c;
      8'h3f:   v = 9'h03f;
      8'h27:   v = 9'h027;
      8'h22:   v = 9'h022;
      default: v = 9'h100;
    endcase
    return v;
  endfunction

endpackage

// ===== design/stl_front.sv =====
// ----------------------------------------------------------------------------
// stl_front: lexer front end
// classifies each character, keeps mode and position counters, builds jobs
// ----------------------------------------------------------------------------
module stl_front import stl_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    take,
  input  in_req_t req,
  output logic    job_push,
  output job_t    job
);

  lex_mode_t   mode_r, mode_nxt;
  logic [3:0]  nib_r, nib_nxt;
  logic [31:0] row_r, row_nxt;
  logic [31:0] col_r, col_nxt;
  logic [31:0] pos_r, pos_nxt;

  logic [7:0] c;
  logic       eof;
  logic       blank, paren, term;
  logic       idle_has;
  kind_t      idle_kind;
  lex_mode_t  idle_mode;
  logic [4:0] hv;
  logic [8:0] esc;
  logic       any;

  always_comb begin
    c     = req.char_in;
    eof   = req.end_mark;
    blank = is_blank(c);
    paren = (c == CH_OPEN) || (c == CH_CLOSE);
    term  = blank || paren || (c == CH_QUOTE);
    hv    = eof ? 5'h10 : hex_value(c);
    esc   = escape_byte(c);

    // start of a token from idle
    idle_has  = !blank && (c != CH_QUOTE);
    idle_kind = (c == CH_OPEN) ? KIND_OPEN : ((c == CH_CLOSE) ? KIND_CLOSE : KIND_TEXT);
    if (c == CH_QUOTE) idle_mode = MODE_STRING;
    else if (blank || paren) idle_mode = MODE_IDLE;
    else idle_mode = MODE_SYMBOL;

    mode_nxt = mode_r;
    nib_nxt  = nib_r;
    row_nxt  = row_r;
    col_nxt  = col_r;
    pos_nxt  = pos_r;

    if (mode_r != MODE_ERROR && !eof) begin
      pos_nxt = pos_r + 32'd1;
      if (c == CH_LF) begin
        col_nxt = '0;
        row_nxt = row_r + 32'd1;
      end else begin
        col_nxt = col_r + 32'd1;
      end
    end

    any              = 1'b0;
    job.first_kind   = KIND_TEXT;
    job.first_byte   = '0;
    job.two          = 1'b0;
    job.second_kind  = KIND_TEXT;
    job.row          = row_nxt;
    job.col          = col_nxt;
    job.pos          = pos_nxt;

    unique case (mode_r)
      MODE_IDLE: begin
        if (eof) begin
          any            = 1'b1;
          job.first_kind = KIND_EOF;
        end else begin
          any            = idle_has;
          job.first_kind = idle_kind;
          job.first_byte = (idle_kind == KIND_TEXT) ? c : 8'd0;
          mode_nxt       = idle_mode;
        end
      end
      MODE_SYMBOL: begin
        if (eof) begin
          any             = 1'b1;
          job.first_kind  = KIND_SYMEND;
          job.two         = 1'b1;
          job.second_kind = KIND_EOF;
          mode_nxt        = MODE_IDLE;
        end else if (term) begin
          any             = 1'b1;
          job.first_kind  = KIND_SYMEND;
          job.two         = idle_has;
          job.second_kind = idle_kind;
          mode_nxt        = idle_mode;
        end else begin
          any            = 1'b1;
          job.first_byte = c;
        end
      end
      MODE_STRING: begin
        if (eof) begin
          any            = 1'b1;
          job.first_kind = KIND_ERROR;
          mode_nxt       = MODE_ERROR;
        end else if (c == CH_QUOTE) begin
          any            = 1'b1;
          job.first_kind = KIND_STREND;
          mode_nxt       = MODE_IDLE;
        end else if (c == CH_BSLASH) begin
          mode_nxt = MODE_ESCAPE;
        end else begin
          any            = 1'b1;
          job.first_byte = c;
        end
      end
      MODE_ESCAPE: begin
        if (!eof && c == CH_X) begin
          mode_nxt = MODE_HEX1;
        end else if (eof || esc[8]) begin
          any            = 1'b1;
          job.first_kind = KIND_ERROR;
          mode_nxt       = MODE_ERROR;
        end else begin
          any            = 1'b1;
          job.first_byte = esc[7:0];
          mode_nxt       = MODE_STRING;
        end
      end
      MODE_HEX1: begin
        if (hv[4]) begin
          any            = 1'b1;
          job.first_kind = KIND_ERROR;
          mode_nxt       = MODE_ERROR;
        end else begin
          nib_nxt  = hv[3:0];
          mode_nxt = MODE_HEX2;
        end
      end
      MODE_HEX2: begin
        if (hv[4]) begin
          any            = 1'b1;
          job.first_kind = KIND_ERROR;
          mode_nxt       = MODE_ERROR;
        end else begin
          any            = 1'b1;
          job.first_byte = {nib_r, hv[3:0]};
          mode_nxt       = MODE_STRING;
        end
      end
      default: begin
        mode_nxt = MODE_ERROR;
      end
    endcase

    job_push = take && any;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      nib_r  <= '0;
      row_r  <= '0;
      col_r  <= '0;
      pos_r  <= '0;
    end else if (take) begin
      mode_r <= mode_nxt;
      nib_r  <= nib_nxt;
      row_r  <= row_nxt;
      col_r  <= col_nxt;
      pos_r  <= pos_nxt;
    end
  end

endmodule

// ===== design/stl_queue.sv =====
// ----------------------------------------------------------------------------
// stl_queue: job queue between front and back end
// small register queue with a count, head readable without delay
// ----------------------------------------------------------------------------
module stl_queue import stl_pkg::*; #(
  parameter int unsigned DEPTH = STL_QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic wr,
  input  job_t wdata,
  input  logic rd,
  output job_t rdata,
  output logic empty,
  output logic full
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  job_t             slots_r [DEPTH];
  logic [PTR_W-1:0] wp_r, wp_nxt;
  logic [PTR_W-1:0] rp_r, rp_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (wr) wp_nxt = (wp_r == PTR_W'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
    if (rd) rp_nxt = (rp_r == PTR_W'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
    if (wr && !rd) cnt_nxt = cnt_r + 1'b1;
    else if (rd && !wr) cnt_nxt = cnt_r - 1'b1;
  end

  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == CNT_W'(DEPTH));
  assign rdata = slots_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) slots_r[wp_r] <= wdata;
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !wr || rd) else $error("job queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    empty |-> !rd) else $error("job queue read while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH)) else $error("job queue count out of range");
`endif

endmodule

// ===== design/stl_back.sv =====
// ----------------------------------------------------------------------------
// stl_back: lexer back end
// unpacks each job into one or two results through the output register
// ----------------------------------------------------------------------------
module stl_back import stl_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     q_empty,
  input  job_t     q_job,
  output logic     q_pop,
  input  logic     pop,
  output logic     empty,
  output out_req_t out_data
);

  out_req_t out_r, out_nxt;
  logic     valid_r, valid_nxt;
  logic     phase_r, phase_nxt;
  logic     load;

  always_comb begin
    load      = !valid_r || pop;
    out_nxt   = out_r;
    valid_nxt = valid_r;
    phase_nxt = phase_r;
    q_pop     = 1'b0;
    if (load) begin
      valid_nxt = !q_empty;
      if (!q_empty) begin
        out_nxt.result_kind  = phase_r ? q_job.second_kind : q_job.first_kind;
        out_nxt.text_byte    = phase_r ? 8'd0 : q_job.first_byte;
        out_nxt.row_now      = q_job.row;
        out_nxt.column_now   = q_job.col;
        out_nxt.position_now = q_job.pos;
        out_nxt.last_of_run  = phase_r || !q_job.two;
        if (phase_r || !q_job.two) begin
          q_pop     = 1'b1;
          phase_nxt = 1'b0;
        end else begin
          phase_nxt = 1'b1;
        end
      end
    end
  end

  assign empty    = !valid_r;
  assign out_data = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      phase_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

`ifndef SYNTH
  a_phase_holds_job: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r |-> !q_empty) else $error("second result pending without a job");
  a_second_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (load && phase_r) |=> (valid_r && out_r.last_of_run))
    else $error("second result not marked last");
  a_byte_only_text: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && out_r.result_kind != KIND_TEXT) |-> (out_r.text_byte == 8'd0))
    else $error("nonzero byte on a non-text result");
`endif

endmodule

// ===== design/sexpr_token_lexer.sv =====
// ----------------------------------------------------------------------------
// sexpr_token_lexer: streaming s-expression tokenizer
// character-serial lexer with c string escapes and position tracking
// ----------------------------------------------------------------------------
// One request per cycle carries one character or an end-of-input mark; it is
// taken whenever the job queue has room, so input runs at one character per
// clock. The front end decides in that same cycle what the character means
// (white space, paren, symbol byte, string byte, escape, hex digit) and
// updates row, column and position counters, which wrap at 32 bits. Each
// character that produces output becomes one job in a QUEUE_DEPTH deep queue;
// the back end drains it into the output register at one result per clock while
// the consumer pops; a job with two results (symbol end, then a paren or end of
// input) yields them in turn. Results pass the job queue, then the output
// register. Every result carries the counters as they stand after its
// character and flags the last result of that character. Once an error is
// reported the lexer produces nothing more and counts nothing until reset.
module sexpr_token_lexer import stl_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = STL_QUEUE_DEPTH
) (
  input  logic     clk,
  input  logic     rst_n,
  // input request channel
  input  logic     push,
  output logic     full,
  input  in_req_t  in_data,
  // result request channel
  output logic     empty,
  input  logic     pop,
  output out_req_t out_data
);

  // front end to queue
  logic take;
  logic job_push;
  job_t job_in;

  // queue to back end
  job_t q_job;
  logic q_pop;
  logic q_empty;
  logic q_full;

  // input taken whenever the queue has space, independent of output stalls
  assign full = q_full;
  assign take = push && !q_full;

  stl_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .take     (take),
    .req      (in_data),
    .job_push (job_push),
    .job      (job_in)
  );

  // decouples character classification from result delivery
  stl_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (job_push),
    .wdata (job_in),
    .rd    (q_pop),
    .rdata (q_job),
    .empty (q_empty),
    .full  (q_full)
  );

  // splits two-result jobs and holds the head result for the consumer
  stl_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_job    (q_job),
    .q_pop    (q_pop),
    .pop      (pop),
    .empty    (empty),
    .out_data (out_data)
  );

endmodule

// ===== dv/sexpr_token_lexer_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sexpr_token_lexer_tb: self-checking bench for the s-expression lexer
// characters go in through the push/full queue port and tokens come out
// through empty/pop. A mode-aware generator keeps the stream legal so that
// symbols, strings, escapes and hex escapes all get exercised. A scoreboard
// class predicts every token with its counters and checks it field by field.
// One error case closes the run, because an error locks the lexer until reset.
// ----------------------------------------------------------------------------
module sexpr_token_lexer_tb;
  import stl_pkg::*;

  localparam int unsigned HALF_PERIOD  = 5;
  localparam int unsigned RANDOM_CHARS = 1880;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam longint unsigned RUN_LIMIT_NS = 64'd10_000_000;

  // own character classes and escape decode for the prediction
  function automatic logic blank_char(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0d);
  endfunction

  // bit 4 set means not a hex digit
  function automatic logic [4:0] hex_digit_value(input logic [7:0] c);
    if (c >= "0" && c <= "9") return {1'b0, 4'(c - "0")};
    if (c >= "a" && c <= "f") return {1'b0, 4'(c - "a" + 8'd10)};
    if (c >= "A" && c <= "F") return {1'b0, 4'(c - "A" + 8'd10)};
    return 5'h10;
  endfunction

  // bit 8 set means the letter is not a known escape
  function automatic logic [8:0] escape_code(input logic [7:0] c);
    case (c)
      "a":     return 9'd7;
      "b":     return 9'd8;
      "f":     return 9'd12;
      "n":     return 9'd10;
      "r":     return 9'd13;
      "t":     return 9'd9;
      "v":     return 9'd11;
      "\\":    return {1'b0, c};
      "?":     return {1'b0, c};
      "'":     return {1'b0, c};
      "\"":    return {1'b0, c};
      default: return 9'h100;
    endcase
  endfunction

  // token predictor plus the queue of tokens still owed by the lexer
  class token_ledger;
    lex_mode_t   mode;
    logic [3:0]  high_digit;
    logic [31:0] rows;
    logic [31:0] cols;
    logic [31:0] chars;
    out_req_t    expected_tokens[$];
    out_req_t    pend[2];
    int unsigned npend;
    int unsigned mismatches;

    function new();
      mode = MODE_IDLE;
      high_digit = '0;
      rows = '0;
      cols = '0;
      chars = '0;
      npend = 0;
      mismatches = 0;
    endfunction

    function void add(kind_t k, logic [7:0] b);
      out_req_t t;
      t.result_kind  = k;
      t.text_byte    = b;
      t.row_now      = rows;
      t.column_now   = cols;
      t.position_now = chars;
      t.last_of_run  = 1'b0;
      pend[npend] = t;
      npend++;
    endfunction

    function void fail_lex();
      mode = MODE_ERROR;
      add(KIND_ERROR, 8'h00);
    endfunction

    // a character seen between tokens
    function void start_token(logic [7:0] c);
      if (blank_char(c)) return;
      if (c == CH_OPEN) add(KIND_OPEN, 8'h00);
      else if (c == CH_CLOSE) add(KIND_CLOSE, 8'h00);
      else if (c == CH_QUOTE) mode = MODE_STRING;
      else begin
        mode = MODE_SYMBOL;
        add(KIND_TEXT, c);
      end
    endfunction

    // accepted character request: work out the tokens it causes
    function void note_char(in_req_t r);
      logic [7:0] c;
      logic       eom;
      logic [8:0] esc;
      logic [4:0] nib;
      c = r.char_in;
      eom = r.end_mark;
      npend = 0;
      if (mode == MODE_ERROR) return;
      if (!eom) begin
        chars++;
        if (c == CH_LF) begin
          cols = '0;
          rows++;
        end else begin
          cols++;
        end
      end
      case (mode)
        MODE_IDLE: begin
          if (eom) add(KIND_EOF, 8'h00);
          else start_token(c);
        end
        MODE_SYMBOL: begin
          if (eom) begin
            add(KIND_SYMEND, 8'h00);
            add(KIND_EOF, 8'h00);
            mode = MODE_IDLE;
          end else if (blank_char(c) || c == CH_OPEN || c == CH_CLOSE || c == CH_QUOTE) begin
            // terminator also starts the next token
            add(KIND_SYMEND, 8'h00);
            mode = MODE_IDLE;
            start_token(c);
          end else begin
            add(KIND_TEXT, c);
          end
        end
        MODE_STRING: begin
          if (eom) fail_lex();
          else if (c == CH_QUOTE) begin
            add(KIND_STREND, 8'h00);
            mode = MODE_IDLE;
          end else if (c == CH_BSLASH) mode = MODE_ESCAPE;
          else add(KIND_TEXT, c);
        end
        MODE_ESCAPE: begin
          if (eom) fail_lex();
          else if (c == CH_X) mode = MODE_HEX1;
          else begin
            esc = escape_code(c);
            if (esc[8]) fail_lex();
            else begin
              add(KIND_TEXT, esc[7:0]);
              mode = MODE_STRING;
            end
          end
        end
        MODE_HEX1: begin
          nib = eom ? 5'h10 : hex_digit_value(c);
          if (nib[4]) fail_lex();
          else begin
            high_digit = nib[3:0];
            mode = MODE_HEX2;
          end
        end
        default: begin
          nib = eom ? 5'h10 : hex_digit_value(c);
          if (nib[4]) fail_lex();
          else begin
            add(KIND_TEXT, {high_digit, nib[3:0]});
            mode = MODE_STRING;
          end
        end
      endcase
      if (npend != 0) pend[npend-1].last_of_run = 1'b1;
      for (int unsigned i = 0; i < npend; i++) expected_tokens.push_back(pend[i]);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_token(out_req_t got);
      out_req_t want;
      if (expected_tokens.size() == 0) begin
        $error("result_kind: expected no result, got %0d", got.result_kind);
        mismatches++;
        return;
      end
      want = expected_tokens.pop_front();
      compare_field("result_kind", want.result_kind, got.result_kind);
      compare_field("text_byte", want.text_byte, got.text_byte);
      compare_field("row_now", want.row_now, got.row_now);
      compare_field("column_now", want.column_now, got.column_now);
      compare_field("position_now", want.position_now, got.position_now);
      compare_field("last_of_run", want.last_of_run, got.last_of_run);
    endfunction

    function int unsigned pending();
      return expected_tokens.size();
    endfunction
  endclass

  logic     clk = 1'b0;
  logic     rst_n;
  logic     push;
  logic     full;
  in_req_t  in_data;
  logic     empty;
  logic     pop;
  out_req_t out_data;

  token_ledger ledger;
  bit          steady;   // set: no idle cycles on either side

  sexpr_token_lexer dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_data  (in_data),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // idle stretch length: mostly none or short, now and then long
  function automatic int unsigned gap_len();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] blank_pick();
    int unsigned i;
    i = $urandom_range(0, 5);
    return (i == 5) ? 8'h20 : 8'(8'h09 + i);
  endfunction

  function automatic logic [7:0] hex_pick();
    logic [3:0] v;
    v = 4'($urandom);
    if (v < 10) return 8'("0" + v);
    // letters in both cases
    return $urandom_range(0, 1) ? 8'("a" + v - 10) : 8'("A" + v - 10);
  endfunction

  function automatic logic [7:0] escape_pick();
    case ($urandom_range(0, 10))
      0:       return "a";
      1:       return "b";
      2:       return "f";
      3:       return "n";
      4:       return "r";
      5:       return "t";
      6:       return "v";
      7:       return "\\";
      8:       return "?";
      9:       return "'";
      default: return "\"";
    endcase
  endfunction

  // next legal character for the lexer's present mode, random content
  function automatic in_req_t pick_char(lex_mode_t m);
    in_req_t     r;
    int unsigned w;
    r.char_in = 8'($urandom);
    r.end_mark = 1'b0;
    w = $urandom_range(0, 99);
    case (m)
      MODE_IDLE: begin
        if (w < 20) r.char_in = blank_pick();
        else if (w < 30) r.char_in = CH_OPEN;
        else if (w < 40) r.char_in = CH_CLOSE;
        else if (w < 55) r.char_in = CH_QUOTE;
        else if (w < 62) r.end_mark = 1'b1;
      end
      MODE_SYMBOL: begin
        if (w < 70) ;
        else if (w < 80) r.char_in = blank_pick();
        else if (w < 87) r.char_in = w[0] ? CH_OPEN : CH_CLOSE;
        else if (w < 93) r.char_in = CH_QUOTE;
        else r.end_mark = 1'b1;
      end
      MODE_STRING: begin
        if (w < 65) ;
        else if (w < 82) r.char_in = CH_BSLASH;
        else r.char_in = CH_QUOTE;
      end
      MODE_ESCAPE: r.char_in = (w < 25) ? CH_X : escape_pick();
      default:     r.char_in = hex_pick();
    endcase
    return r;
  endfunction

  // one character request, after a random hold-off, until accepted
  task automatic drive_one(input in_req_t r);
    int unsigned g;
    bit          taken;
    g = gap_len();
    if (g != 0) begin
      push <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_data <= r;
    push    <= 1'b1;
    // full is stable between the falling edge and the next rising edge
    do begin
      @(negedge clk);
      taken = !full;
      @(posedge clk);
    end while (!taken);
    ledger.note_char(r);
  endtask

  task automatic put_char(input logic [7:0] c);
    in_req_t r;
    r.char_in = c;
    r.end_mark = 1'b0;
    drive_one(r);
  endtask

  task automatic put_end();
    in_req_t r;
    r.char_in = 8'($urandom);
    r.end_mark = 1'b1;
    drive_one(r);
  endtask

  // closes the run with one of the error cases, picked at random
  task automatic drive_failure();
    int unsigned how;
    logic [7:0]  c;
    logic [8:0]  ev;
    logic [4:0]  hv;
    how = $urandom_range(0, 4);
    // finish whatever token is open
    while (ledger.mode != MODE_IDLE) begin
      case (ledger.mode)
        MODE_SYMBOL: put_char(CH_SPACE);
        MODE_STRING: put_char(CH_QUOTE);
        MODE_ESCAPE: put_char("n");
        default:     put_char(hex_pick());
      endcase
    end
    put_char(CH_QUOTE);
    put_char("k");
    if (how >= 1) put_char(CH_BSLASH);
    if (how >= 3) put_char(CH_X);
    if (how >= 4) put_char(hex_pick());
    case (how)
      0, 1: put_end();    // unterminated string or escape
      2: begin            // unknown escape letter
        do begin
          c  = 8'($urandom);
          ev = escape_code(c);
        end while (!ev[8] || c == CH_X);
        put_char(c);
      end
      default: begin      // bad first or second hex digit
        if ($urandom_range(0, 3) == 0) put_end();
        else begin
          do begin
            c  = 8'($urandom);
            hv = hex_digit_value(c);
          end while (!hv[4]);
          put_char(c);
        end
      end
    endcase
    // the lexer must stay silent from here on
    repeat (4) begin
      if ($urandom_range(0, 3) == 0) put_end();
      else put_char(8'($urandom));
    end
  endtask

  // result side: pop with random stalls, check at the falling edge
  initial begin : result_side
    int unsigned stall;
    stall = 0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (stall != 0) begin
        pop <= 1'b0;
        stall--;
      end else begin
        pop   <= 1'b1;
        stall = gap_len();
      end
      @(negedge clk);
      if (pop && !empty) ledger.check_token(out_data);
      @(posedge clk);
    end
  end

  initial begin : run_limit
    #(RUN_LIMIT_NS);
    $display("[sexpr_token_lexer] ERROR");
    $finish;
  end

  initial begin : stimulus
    ledger  = new();
    steady  = 1'b0;
    rst_n   <= 1'b0;
    push    <= 1'b0;
    pop     <= 1'b0;
    in_data <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: end mark between tokens, both parens
    put_end();
    put_char(CH_OPEN);
    put_char(CH_CLOSE);
    // symbol of the extreme bytes, ended by a close paren
    put_char(8'h00);
    put_char(8'hff);
    put_char(CH_CLOSE);
    // symbol ended by an open paren, then one ended by a quote
    put_char("a");
    put_char(CH_OPEN);
    put_char("b");
    put_char(CH_QUOTE);
    // string with a letter escape and hex escapes in both cases
    put_char("q");
    put_char(CH_BSLASH);
    put_char("n");
    put_char(CH_BSLASH);
    put_char(CH_X);
    put_char("A");
    put_char("f");
    put_char(CH_BSLASH);
    put_char(CH_X);
    put_char("0");
    put_char("9");
    put_char(CH_QUOTE);
    // symbol ended by a newline, then one ended by the end mark
    put_char("c");
    put_char(CH_LF);
    put_char("d");
    put_end();

    // random legal stream, with one stretch of back-to-back traffic
    for (int unsigned i = 0; i < RANDOM_CHARS; i++) begin
      steady = (i >= 600 && i < 900);
      drive_one(pick_char(ledger.mode));
    end
    steady = 1'b0;

    drive_failure();
    push <= 1'b0;

    while (ledger.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (ledger.mismatches == 0) begin
      $display("[sexpr_token_lexer] OK");
    end else begin
      $display("[sexpr_token_lexer] ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/stl_pkg.sv
design/stl_front.sv
design/stl_queue.sv
design/stl_back.sv
design/sexpr_token_lexer.sv
dv/sexpr_token_lexer_tb.sv
